// File: rtl/core/gdda_pkg.sv
// Shared types, constants and calendar tables of the Gregorian date unit.
`timescale 1ns / 1ps
package gdda_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BEFORE  = 2'd1,
    ST_PAST    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  localparam logic CMD_SHIFT = 1'b0;
  localparam logic CMD_DIST  = 1'b1;

  localparam int DayW  = 23;  // day number of a valid input date
  localparam int NW    = 26;  // signed shifted day number
  localparam int RW    = 25;  // zero-based shifted day number
  localparam int DistW = 22;
  localparam int YyW   = 17;

  localparam int Days400 = 146097;
  localparam int Days100 = 36524;
  localparam int Days4   = 1461;

  typedef struct packed {
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
  } date_t;

  typedef struct packed {
    logic        ok;
    logic [13:0] p;     // year minus one
    logic [7:0]  pq;    // (year - 1) / 100
    logic [8:0]  cumd;  // days before the month plus day of month
  } dpart_t;

  typedef struct packed {
    status_t             status;
    logic [DistW-1:0]    span;
    logic                date_en;
  } cry_t;

  // Days before month m in a common year.
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] l;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   l = 5'd30;
      4'd2:                                      l = leap ? 5'd29 : 5'd28;
      default:                                   l = 5'd0;
    endcase
    return l;
  endfunction

endpackage

// File: rtl/core/gregorian_date_day_arithmetic.sv
// Top level of the pipelined proleptic Gregorian date shift and distance unit.
`timescale 1ns / 1ps
// Takes one word per cycle and returns one result word for each; the pipeline
// depth is set by the chain of reciprocal-multiply divisions (by 146097 and
// 1461) and their correction steps that turn a day number back into a date.
// A stall on the output holds the whole pipeline, so input words are taken
// only while the output register is free or being read. Command 0 shifts the
// first date by the signed offset, command 1 gives the absolute day distance
// between both dates. Status in out_tuser reports an invalid input date or a
// shifted date outside year 1 through MAX_YEAR; those results carry zeros.
module gregorian_date_day_arithmetic #(
  parameter int MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_day, first_month, first_year, offset, second_day, second_month,
  // second_year, zero fill
  input  logic [71:0] in_tdata,
  input  logic [0:0]  in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_day, result_month, result_year, distance, zero fill
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser   // status
);

  localparam int NStg = 14;
  localparam int LastDay = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

  logic en;
  logic [NStg-1:0] vld_r;

  // stage 1
  gdda_pkg::date_t s1_a_r, s1_b_r;
  logic [7:0] s1_yqa_r, s1_yqb_r, yqa_nxt, yqb_nxt;
  logic s1_cmd_r;
  logic signed [22:0] s1_off_r;
  gdda_pkg::date_t in_a, in_b;
  // stage 2
  gdda_pkg::dpart_t s2_a_r, s2_b_r, pa_nxt, pb_nxt;
  logic s2_cmd_r;
  logic signed [22:0] s2_off_r;
  // stage 3
  logic [gdda_pkg::DayW-1:0] s3_dna_r, s3_dnb_r, dna_nxt, dnb_nxt;
  logic s3_inv_r, s3_cmd_r;
  logic signed [22:0] s3_off_r;
  // stage 4
  logic signed [gdda_pkg::NW-1:0] s4_n_r, n_nxt;
  logic [gdda_pkg::DayW-1:0] s4_diff_r, diff_nxt;
  logic s4_inv_r, s4_cmd_r;
  // stage 5 and the carried status
  logic [gdda_pkg::RW-1:0] s5_r_r, r_nxt;
  gdda_pkg::cry_t cry_nxt;
  gdda_pkg::cry_t cry_r [5:13];
  // four-hundred-year split
  logic [7:0] s6_q_r, q400a_nxt;
  logic [gdda_pkg::RW-1:0] s6_r_r;
  logic [18:0] s7_rem_r, rem400_nxt;
  logic [7:0] s7_q_r;
  logic [17:0] s8_r_r, r1_nxt;
  logic [7:0] s8_q400_r, q400_nxt;
  // century split
  logic [15:0] s9_r_r, r2_nxt;
  logic [1:0] s9_q100_r, q100_nxt;
  logic [7:0] s9_q400_r;
  // four-year split
  logic [15:0] s10_r_r;
  logic [4:0] s10_q_r, q4a_nxt;
  logic [7:0] s10_q400_r;
  logic [1:0] s10_q100_r;
  logic [11:0] s11_rem_r, rem4_nxt;
  logic [4:0] s11_q_r;
  logic [7:0] s11_q400_r;
  logic [1:0] s11_q100_r;
  logic [10:0] s12_r_r, r3_nxt;
  logic [4:0] s12_q4_r, q4_nxt;
  logic [7:0] s12_q400_r;
  logic [1:0] s12_q100_r;
  // single years and month
  logic [8:0] s13_r_r, r4_nxt;
  logic [gdda_pkg::YyW-1:0] s13_yy_r, yy_nxt;
  logic s13_leap_r, leap_nxt;
  logic [1:0] q1_nxt;
  logic [3:0] mm_nxt;
  logic [4:0] rd_nxt;
  logic [8:0] cum_sel;
  // output register
  logic [4:0] rd_r;
  logic [3:0] rm_r;
  logic [13:0] ry_r;
  logic [gdda_pkg::DistW-1:0] dist_r;
  gdda_pkg::status_t status_r;

  assign en        = !vld_r[NStg-1] || out_tready;
  assign in_tready = en;

  assign in_a = '{y: in_tdata[22:9], m: in_tdata[8:5], d: in_tdata[4:0]};
  assign in_b = '{y: in_tdata[68:55], m: in_tdata[54:51], d: in_tdata[50:46]};

  // Year divided by 100 through a reciprocal, exact for any 14-bit year.
  assign yqa_nxt = 8'((27'(in_a.y) * 27'd5243) >> 19);
  assign yqb_nxt = 8'((27'(in_b.y) * 27'd5243) >> 19);

  function automatic gdda_pkg::dpart_t date_part(input gdda_pkg::date_t dt,
                                                  input logic [7:0] yq);
    gdda_pkg::dpart_t o;
    logic [13:0] rem100;
    logic z100, leap, mok;
    rem100 = dt.y - 14'(yq) * 14'd100;
    z100   = (rem100 == 14'd0);
    leap   = (dt.y[1:0] == 2'd0 && !z100) || (z100 && yq[1:0] == 2'd0);
    mok    = (dt.m >= 4'd1) && (dt.m <= 4'd12);
    o.ok   = (dt.y != 14'd0) && (17'(dt.y) <= 17'(MAX_YEAR)) && mok &&
             (dt.d != 5'd0) && (dt.d <= gdda_pkg::month_len(dt.m, leap));
    o.p    = dt.y - 14'd1;
    o.pq   = z100 ? yq - 8'd1 : yq;
    o.cumd = gdda_pkg::cum_days(dt.m) + 9'(leap && dt.m > 4'd2) + 9'(dt.d);
    return o;
  endfunction

  assign pa_nxt = date_part(s1_a_r, s1_yqa_r);
  assign pb_nxt = date_part(s1_b_r, s1_yqb_r);

  function automatic logic [gdda_pkg::DayW-1:0] day_num(input gdda_pkg::dpart_t dp);
    return 23'(dp.p) * 23'd365 + 23'(dp.p >> 2) - 23'(dp.pq) + 23'(dp.pq >> 2)
           + 23'(dp.cumd);
  endfunction

  assign dna_nxt = day_num(s2_a_r);
  assign dnb_nxt = day_num(s2_b_r);

  assign n_nxt    = $signed({3'b000, s3_dna_r}) + {{3{s3_off_r[22]}}, s3_off_r};
  assign diff_nxt = (s3_dna_r >= s3_dnb_r) ? s3_dna_r - s3_dnb_r : s3_dnb_r - s3_dna_r;

  always_comb begin
    cry_nxt = '{status: gdda_pkg::ST_OK, span: '0, date_en: 1'b0};
    if (s4_inv_r) begin
      cry_nxt.status = gdda_pkg::ST_INVALID;
    end else if (s4_cmd_r == gdda_pkg::CMD_SHIFT) begin
      if (s4_n_r < $signed(26'sd1)) begin
        cry_nxt.status = gdda_pkg::ST_BEFORE;
      end else if (s4_n_r > $signed(26'(LastDay))) begin
        cry_nxt.status = gdda_pkg::ST_PAST;
      end else begin
        cry_nxt.date_en = 1'b1;
      end
    end else begin
      cry_nxt.span = (s4_diff_r > 23'h3FFFFF) ? '1 : s4_diff_r[gdda_pkg::DistW-1:0];
    end
  end
  assign r_nxt = gdda_pkg::RW'(s4_n_r - 26'sd1);

  // Quotients from a reciprocal may come out one low; a compare fixes that.
  assign q400a_nxt  = 8'((40'(s5_r_r) * 40'd29398) >> 32);
  assign rem400_nxt = 19'(26'(s6_r_r) - 26'(s6_q_r) * 26'(gdda_pkg::Days400));
  always_comb begin
    if (s7_rem_r >= 19'(gdda_pkg::Days400)) begin
      q400_nxt = s7_q_r + 8'd1;
      r1_nxt   = 18'(s7_rem_r - 19'(gdda_pkg::Days400));
    end else begin
      q400_nxt = s7_q_r;
      r1_nxt   = s7_rem_r[17:0];
    end
  end

  // The last century of an era is one day longer, hence the cap at three.
  always_comb begin
    if (s8_r_r >= 18'(3 * gdda_pkg::Days100)) begin
      q100_nxt = 2'd3;
      r2_nxt   = 16'(s8_r_r - 18'(3 * gdda_pkg::Days100));
    end else if (s8_r_r >= 18'(2 * gdda_pkg::Days100)) begin
      q100_nxt = 2'd2;
      r2_nxt   = 16'(s8_r_r - 18'(2 * gdda_pkg::Days100));
    end else if (s8_r_r >= 18'(gdda_pkg::Days100)) begin
      q100_nxt = 2'd1;
      r2_nxt   = 16'(s8_r_r - 18'(gdda_pkg::Days100));
    end else begin
      q100_nxt = 2'd0;
      r2_nxt   = s8_r_r[15:0];
    end
  end

  assign q4a_nxt  = 5'((38'(s9_r_r) * 38'd2939744) >> 32);
  assign rem4_nxt = 12'(16'(s10_r_r) - 16'(s10_q_r) * 16'(gdda_pkg::Days4));
  always_comb begin
    if (s11_rem_r >= 12'(gdda_pkg::Days4)) begin
      q4_nxt = s11_q_r + 5'd1;
      r3_nxt = 11'(s11_rem_r - 12'(gdda_pkg::Days4));
    end else begin
      q4_nxt = s11_q_r;
      r3_nxt = s11_rem_r[10:0];
    end
  end

  always_comb begin
    if (s12_r_r >= 11'd1095) begin
      q1_nxt = 2'd3;
      r4_nxt = 9'(s12_r_r - 11'd1095);
    end else if (s12_r_r >= 11'd730) begin
      q1_nxt = 2'd2;
      r4_nxt = 9'(s12_r_r - 11'd730);
    end else if (s12_r_r >= 11'd365) begin
      q1_nxt = 2'd1;
      r4_nxt = 9'(s12_r_r - 11'd365);
    end else begin
      q1_nxt = 2'd0;
      r4_nxt = s12_r_r[8:0];
    end
  end
  // The year is leap when it ends a four-year block that is not the short
  // end of a century, unless the century is the last one of its era.
  assign leap_nxt = (q1_nxt == 2'd3) && ((s12_q4_r != 5'd24) || (s12_q100_r == 2'd3));
  assign yy_nxt = 17'(s12_q400_r) * 17'd400 + 17'(s12_q100_r) * 17'd100
                + 17'(s12_q4_r) * 17'd4 + 17'(q1_nxt) + 17'd1;

  always_comb begin
    mm_nxt = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (s13_r_r >= gdda_pkg::cum_days(4'(i)) + 9'(s13_leap_r && i > 2)) begin
        mm_nxt = 4'(i);
      end
    end
    cum_sel = gdda_pkg::cum_days(mm_nxt) + 9'(s13_leap_r && mm_nxt > 4'd2);
    rd_nxt  = 5'(s13_r_r - cum_sel + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NStg-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r   <= in_a;
      s1_b_r   <= in_b;
      s1_yqa_r <= yqa_nxt;
      s1_yqb_r <= yqb_nxt;
      s1_cmd_r <= in_tuser[0];
      s1_off_r <= in_tdata[45:23];

      s2_a_r   <= pa_nxt;
      s2_b_r   <= pb_nxt;
      s2_cmd_r <= s1_cmd_r;
      s2_off_r <= s1_off_r;

      s3_dna_r <= dna_nxt;
      s3_dnb_r <= dnb_nxt;
      s3_inv_r <= !s2_a_r.ok || (s2_cmd_r == gdda_pkg::CMD_DIST && !s2_b_r.ok);
      s3_cmd_r <= s2_cmd_r;
      s3_off_r <= s2_off_r;

      s4_n_r    <= n_nxt;
      s4_diff_r <= diff_nxt;
      s4_inv_r  <= s3_inv_r;
      s4_cmd_r  <= s3_cmd_r;

      s5_r_r    <= r_nxt;
      cry_r[5]  <= cry_nxt;
      for (int k = 6; k <= 13; k++) begin
        cry_r[k] <= cry_r[k-1];
      end

      s6_q_r <= q400a_nxt;
      s6_r_r <= s5_r_r;

      s7_rem_r <= rem400_nxt;
      s7_q_r   <= s6_q_r;

      s8_r_r    <= r1_nxt;
      s8_q400_r <= q400_nxt;

      s9_r_r    <= r2_nxt;
      s9_q100_r <= q100_nxt;
      s9_q400_r <= s8_q400_r;

      s10_r_r    <= s9_r_r;
      s10_q_r    <= q4a_nxt;
      s10_q400_r <= s9_q400_r;
      s10_q100_r <= s9_q100_r;

      s11_rem_r  <= rem4_nxt;
      s11_q_r    <= s10_q_r;
      s11_q400_r <= s10_q400_r;
      s11_q100_r <= s10_q100_r;

      s12_r_r    <= r3_nxt;
      s12_q4_r   <= q4_nxt;
      s12_q400_r <= s11_q400_r;
      s12_q100_r <= s11_q100_r;

      s13_r_r    <= r4_nxt;
      s13_yy_r   <= yy_nxt;
      s13_leap_r <= leap_nxt;

      status_r <= cry_r[13].status;
      dist_r   <= cry_r[13].span;
      rd_r     <= cry_r[13].date_en ? rd_nxt : 5'd0;
      rm_r     <= cry_r[13].date_en ? mm_nxt : 4'd0;
      ry_r     <= cry_r[13].date_en ? s13_yy_r[13:0] : 14'd0;
    end
  end

  assign out_tvalid = vld_r[NStg-1];
  assign out_tdata  = {3'b000, dist_r, ry_r, rm_r, rd_r};
  assign out_tuser  = status_r;

  // A failed status never comes with a date or a distance.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status_r != gdda_pkg::ST_OK |-> out_tdata[44:0] == 45'd0)
    else $error("failed status carries data");

  // A word never carries both a date and a distance.
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> dist_r == '0 || (rd_r == 5'd0 && rm_r == 4'd0 && ry_r == 14'd0))
    else $error("date and distance both set");

  // A returned date has a proper month and day.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && rm_r != 4'd0 |-> rm_r <= 4'd12 && rd_r != 5'd0 && rd_r <= 5'd31)
    else $error("returned date out of range");

  // While the output stalls, no word moves inside the pipeline.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule
